[hw/rtl/lgis_pkg.sv]
// ----------------------------------------------------------------------------
// Leftmost greater index search package
// Shared sizes, codes and state type of the search block.
// ----------------------------------------------------------------------------
package lgis_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int HEIGHT_BITS = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WAIT_A,
        ST_WAIT_B,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

[hw/rtl/lgis_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lgis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/leftmost_greater_index_search.sv]
// ----------------------------------------------------------------------------
// Leftmost greater index search
// A query whose positions are equal or out of use, or whose larger position
// holds the greater height, is answered without a scan. Otherwise the height
// memory is read one position per cycle from just after the larger position,
// at most n_eff minus one minus that position reads, where n_eff is used_count
// capped at 1024; the single read port of the height memory sets this rate.
// A result that the receiver holds back adds its wait before the next transfer
// is accepted. After reset a clearing pass zeroes the height memory, during
// which no transfer is accepted.
// ----------------------------------------------------------------------------
module leftmost_greater_index_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,      // used_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,     // first_index, second_index, height_value
    input  logic        s_axis_tuser,     // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,     // meeting_index
    output logic        m_axis_tuser      // found
);

    import lgis_pkg::*;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_used;
    logic [IDX_W-1:0]       r_a, n_a, r_b, n_b;
    logic [HEIGHT_BITS-1:0] r_ha, n_ha, r_hmax, n_hmax;
    logic [CNT_W-1:0]       r_ptr, n_ptr;
    logic                   r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]       r_rd_addr, n_rd_addr;
    logic [IDX_W-1:0]       r_res_idx, n_res_idx;
    logic                   r_res_found, n_res_found;
    logic [IDX_W-1:0]       r_clr, n_clr;
    logic                   r_out_valid, n_out_valid;
    logic [IDX_W-1:0]       r_out_idx, n_out_idx;
    logic                   r_out_found, n_out_found;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr, ram_raddr;
    logic [HEIGHT_BITS-1:0] ram_wdata, ram_rdata;

    logic [CNT_W-1:0]       n_eff;
    logic                   accept;
    logic [IDX_W-1:0]       in_a, in_b;
    logic [IDX_W-1:0]       big;
    logic [HEIGHT_BITS-1:0] h_big, h_small;

    lgis_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_heights (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign n_eff  = (r_used > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : r_used;
    assign in_a   = s_axis_tdata[IDX_W-1:0];
    assign in_b   = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    assign big     = (r_a > r_b) ? r_a : r_b;
    assign h_big   = (r_a > r_b) ? r_ha : ram_rdata;
    assign h_small = (r_a > r_b) ? ram_rdata : r_ha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_used      <= CNT_W'(MAX_ENTRIES);
            r_clr       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_used <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_ha        <= n_ha;
        r_hmax      <= n_hmax;
        r_ptr       <= n_ptr;
        r_rd_addr   <= n_rd_addr;
        r_res_idx   <= n_res_idx;
        r_res_found <= n_res_found;
        r_out_idx   <= n_out_idx;
        r_out_found <= n_out_found;
    end

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_ha        = r_ha;
        n_hmax      = r_hmax;
        n_ptr       = r_ptr;
        n_rd_vld    = 1'b0;
        n_rd_addr   = r_rd_addr;
        n_res_idx   = r_res_idx;
        n_res_found = r_res_found;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_idx   = r_out_idx;
        n_out_found = r_out_found;
        ram_we      = 1'b0;
        ram_waddr   = in_a;
        ram_wdata   = s_axis_tdata[2*IDX_W+HEIGHT_BITS-1:2*IDX_W];
        ram_raddr   = in_a;

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == IDX_W'(MAX_ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_a = in_a;
                    n_b = in_b;
                    if (s_axis_tuser == MODE_LOAD) begin
                        ram_we = 1'b1;
                    end else if ({1'b0, in_a} >= n_eff || {1'b0, in_b} >= n_eff) begin
                        n_res_idx   = '0;
                        n_res_found = 1'b0;
                        n_state     = ST_DONE;
                    end else if (in_a == in_b) begin
                        n_res_idx   = in_a;
                        n_res_found = 1'b1;
                        n_state     = ST_DONE;
                    end else begin
                        n_state = ST_WAIT_A;
                    end
                end
            end
            ST_WAIT_A: begin
                n_ha      = ram_rdata;
                ram_raddr = r_b;
                n_state   = ST_WAIT_B;
            end
            ST_WAIT_B: begin
                if (h_big > h_small) begin
                    n_res_idx   = big;
                    n_res_found = 1'b1;
                    n_state     = ST_DONE;
                end else begin
                    n_hmax = h_small;
                    n_ptr  = {1'b0, big} + 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                ram_raddr = r_ptr[IDX_W-1:0];
                if (r_rd_vld && ram_rdata > r_hmax) begin
                    n_res_idx   = r_rd_addr;
                    n_res_found = 1'b1;
                    n_state     = ST_DONE;
                end else if (r_ptr < n_eff) begin
                    n_rd_vld  = 1'b1;
                    n_rd_addr = r_ptr[IDX_W-1:0];
                    n_ptr     = r_ptr + 1'b1;
                end else if (!r_rd_vld) begin
                    n_res_idx   = '0;
                    n_res_found = 1'b0;
                    n_state     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_res_idx;
                    n_out_found = r_res_found;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(16 - IDX_W){1'b0}}, r_out_idx};
    assign m_axis_tuser  = r_out_found;

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("result without a position carries a nonzero index");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> !ram_we)
        else $error("height memory written during a scan");

    a_scan_after_big: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN && r_rd_vld |-> r_rd_addr > big)
        else $error("scan read at or before the larger query position");

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE && r_res_found |-> {1'b0, r_res_idx} < n_eff)
        else $error("found position beyond the entries in use");

endmodule

[tb/sv/leftmost_greater_index_search_tb.sv]
// ----------------------------------------------------------------------------
// Leftmost greater index search testbench
// Drives loads and queries through the input stream and predicts each query
// answer from a private copy of the height array, using a direct scan for
// the leftmost position above both query heights. Results are compared in
// order, and the used count is changed between idle phases.
// ----------------------------------------------------------------------------
module leftmost_greater_index_search_tb;
    import lgis_pkg::*;

    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  first_index;
        logic [IDX_W-1:0]  second_index;
        logic [31:0]       height_value;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0] meeting_index;
        logic             found;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [10:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        s_axis_tready_seen;

    logic [31:0] heights [MAX_ENTRIES];
    int          active_count;
    t_item       pending_items [$];
    t_answer     expected_answers [$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    t_item       cur_item;

    leftmost_greater_index_search uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic enqueue_item(t_item it);
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic t_answer search_answer(t_item it);
        t_answer     ans;
        int          n;
        int          big;
        int          lesser;
        logic [31:0] ha;
        logic [31:0] hb;
        ans = '0;
        n = (active_count > MAX_ENTRIES) ? MAX_ENTRIES : active_count;
        if (it.first_index >= n || it.second_index >= n)
            return ans;
        if (it.first_index == it.second_index) begin
            ans.meeting_index = it.first_index;
            ans.found = 1'b1;
            return ans;
        end
        big = (it.first_index > it.second_index) ? it.first_index : it.second_index;
        lesser = (it.first_index > it.second_index) ? it.second_index : it.first_index;
        if (heights[big] > heights[lesser]) begin
            ans.meeting_index = IDX_W'(big);
            ans.found = 1'b1;
            return ans;
        end
        ha = heights[it.first_index];
        hb = heights[it.second_index];
        for (int p = big + 1; p < n; p++) begin
            if (heights[p] > ha && heights[p] > hb) begin
                ans.meeting_index = IDX_W'(p);
                ans.found = 1'b1;
                return ans;
            end
        end
        return ans;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // Driver: the prediction is made when the transfer completes.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready_seen) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= cur_item.mode;
                s_axis_tdata  <= {4'b0, cur_item.height_value,
                                  cur_item.second_index, cur_item.first_index};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        s_axis_tready_seen <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            if (s_axis_tuser == MODE_LOAD)
                heights[s_axis_tdata[IDX_W-1:0]] <= s_axis_tdata[2*IDX_W +: 32];
            else
                expected_answers.insert(expected_answers.size(), search_answer(
                    {s_axis_tuser, s_axis_tdata[IDX_W-1:0],
                     s_axis_tdata[IDX_W +: IDX_W], 32'd0}));
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[IDX_W-1:0], -1);
            end else begin
                want = expected_answers.pop_front();
                if (m_axis_tuser !== want.found)
                    report_mismatch("found", m_axis_tuser, want.found);
                if (m_axis_tdata !== {6'b0, want.meeting_index})
                    report_mismatch("meeting_index", m_axis_tdata, want.meeting_index);
            end
        end
    end

    function automatic t_item make_load(int idx, logic [31:0] h);
        t_item it;
        it = '0;
        it.mode = MODE_LOAD;
        it.first_index = IDX_W'(idx);
        it.height_value = h;
        return it;
    endfunction

    function automatic t_item make_query(int a, int b);
        t_item it;
        it.mode = MODE_QUERY;
        it.first_index = IDX_W'(a);
        it.second_index = IDX_W'(b);
        it.height_value = $urandom;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
    endtask

    task automatic write_count(int value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 11'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        active_count = value;
    endtask

    // Mostly small index window so the random heights interact.
    task automatic random_phase(int count, int span);
        int a;
        int b;
        for (int k = 0; k < count; k++) begin
            a = $urandom_range(span - 1);
            b = $urandom_range(span - 1);
            if ($urandom_range(9) < 4)
                enqueue_item(make_load(a,
                    ($urandom_range(3) == 0) ? $urandom : $urandom_range(15)));
            else if ($urandom_range(19) == 0)
                enqueue_item(make_query($urandom_range(1023),
                                        $urandom_range(1023)));
            else
                enqueue_item(make_query(a, b));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        mismatch_count = 0;
        active_count = MAX_ENTRIES;
        send_idle_pct = 37;
        recv_idle_pct = 86;
        foreach (heights[i]) heights[i] = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: all-zero ties, extremes, equal positions.
        enqueue_item(make_query(0, 0));
        enqueue_item(make_query(1023, 1023));
        enqueue_item(make_query(0, 5));
        enqueue_item(make_load(1023, 32'hFFFF_FFFF));
        enqueue_item(make_load(0, 32'd0));
        enqueue_item(make_load(3, 32'd7));
        enqueue_item(make_load(5, 32'd7));
        enqueue_item(make_load(9, 32'd8));
        enqueue_item(make_query(3, 5));
        enqueue_item(make_query(5, 3));
        enqueue_item(make_query(0, 3));
        enqueue_item(make_query(1023, 0));
        enqueue_item(make_query(9, 1022));
        enqueue_item(make_query(10, 1023));
        enqueue_item(make_load(1023, 32'd0));
        enqueue_item(make_query(9, 1022));
        wait_drained();

        write_count(16);
        enqueue_item(make_query(3, 5));
        enqueue_item(make_query(15, 15));
        enqueue_item(make_query(16, 0));
        random_phase(500, 20);
        wait_drained();

        send_idle_pct = 86;
        recv_idle_pct = 37;
        write_count(1);
        enqueue_item(make_query(0, 0));
        enqueue_item(make_query(1, 0));
        random_phase(100, 4);
        wait_drained();

        write_count(2047);
        random_phase(400, 64);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_count(0);
        random_phase(50, 8);
        wait_drained();
        write_count(1024);
        random_phase(550, 40);
        wait_drained();

        if (mismatch_count == 0 && expected_answers.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #100000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/lgis_pkg.sv
hw/rtl/lgis_ram.sv
hw/rtl/leftmost_greater_index_search.sv
tb/sv/leftmost_greater_index_search_tb.sv
